/* rtl/core/fast_nms_box_suppressor_top_defines.svh */
// assertion macros for the box suppressor
`ifndef FAST_NMS_BOX_SUPPRESSOR_TOP_DEFINES_SVH
`define FAST_NMS_BOX_SUPPRESSOR_TOP_DEFINES_SVH

// implication checked on every clock edge outside reset
`define NMS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// implication with the consequent checked in the cycle after the antecedent
`define NMS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/core/fnms_pkg.sv */
package fnms_pkg;

  localparam int MaxBoxes  = 64;
  localparam int CoordBits = 16;
  localparam int IdxBits   = $clog2(MaxBoxes);
  localparam int CntBits   = $clog2(MaxBoxes + 1);
  localparam int BoxBits   = 4 * CoordBits;
  // overlap at twice scale, one bit of headroom
  localparam int OvBits    = CoordBits + 2;
  localparam int AreaBits  = 2 * OvBits;
  localparam int UniBits   = AreaBits + 1;
  localparam int ThrBits   = 16;
  localparam logic [ThrBits-1:0] ThrReset = 16'd29491;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [CoordBits-1:0] cx;
    logic [CoordBits-1:0] cy;
    logic [CoordBits-1:0] sx;
    logic [CoordBits-1:0] sy;
  } box_t;

  // pipeline control between sequencer and pair unit
  typedef struct packed {
    logic valid;
  } pair_ctl_t;

endpackage

/* rtl/core/fnms_if.sv */
interface fnms_in_if (input logic clk);
  logic                          valid;
  logic                          ready;
  logic [fnms_pkg::CoordBits-1:0] center_x;
  logic [fnms_pkg::CoordBits-1:0] center_y;
  logic [fnms_pkg::CoordBits-1:0] span_x;
  logic [fnms_pkg::CoordBits-1:0] span_y;
  logic                          last_box;
  modport source (output valid, center_x, center_y, span_x, span_y, last_box, input ready);
  modport sink (input valid, center_x, center_y, span_x, span_y, last_box, output ready);
endinterface

interface fnms_out_if (input logic clk);
  logic valid;
  logic ready;
  logic keep;
  logic overflow;
  logic last_result;
  modport source (output valid, keep, overflow, last_result, input ready);
  modport sink (input valid, keep, overflow, last_result, output ready);
endinterface

/* rtl/core/fnms_ram.sv */
module fnms_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  // write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

/* rtl/core/fnms_pair.sv */
module fnms_pair (
  input  logic                          clk,
  input  logic                          rst,
  input  fnms_pkg::pair_ctl_t           ctl,
  input  fnms_pkg::box_t                a,
  input  fnms_pkg::box_t                b,
  input  logic [fnms_pkg::ThrBits-1:0]  thr,
  output logic                          hit_valid,
  output logic                          hit
);
  localparam int Ov = fnms_pkg::OvBits;
  localparam int Ar = fnms_pkg::AreaBits;
  localparam int Un = fnms_pkg::UniBits;
  localparam int Lh = Un + 16;

  logic [Ov-1:0] ovx, ovy, s2ax, s2ay, s2bx, s2by;
  logic [Ov-1:0] ovx_q, ovy_q, sax_q, say_q, sbx_q, sby_q;
  logic [Ar-1:0] inter_q, area_a_q, area_b_q;
  logic [Un-1:0] uni;
  logic [Un-1:0] uni_q;
  logic [Ar-1:0] inter_q2;
  logic [Lh-1:0] rhs_q;
  logic [Ar-1:0] inter_q3;
  logic          zero_q;
  logic [3:0]    vld;

  // overlap on one axis at twice scale
  function automatic logic [Ov-1:0] ov2(
    input logic [fnms_pkg::CoordBits-1:0] ca, sa, cb, sb
  );
    logic signed [Ov+1:0] la, ha, lb, hb, top, bot;
    la = $signed({2'b00, ca, 1'b0}) - $signed({3'b000, sa});
    ha = $signed({2'b00, ca, 1'b0}) + $signed({3'b000, sa});
    lb = $signed({2'b00, cb, 1'b0}) - $signed({3'b000, sb});
    hb = $signed({2'b00, cb, 1'b0}) + $signed({3'b000, sb});
    top = (ha < hb) ? ha : hb;
    bot = (la > lb) ? la : lb;
    ov2 = (top > bot) ? Ov'(top - bot) : '0;
  endfunction

  // stage 0: overlaps and doubled spans
  assign ovx  = ov2(a.cx, a.sx, b.cx, b.sx);
  assign ovy  = ov2(a.cy, a.sy, b.cy, b.sy);
  assign s2ax = {1'b0, a.sx, 1'b0};
  assign s2ay = {1'b0, a.sy, 1'b0};
  assign s2bx = {1'b0, b.sx, 1'b0};
  assign s2by = {1'b0, b.sy, 1'b0};

  always_ff @(posedge clk) begin
    ovx_q <= ovx;
    ovy_q <= ovy;
    sax_q <= s2ax;
    say_q <= s2ay;
    sbx_q <= s2bx;
    sby_q <= s2by;
    // stage 1: three products
    inter_q  <= ovx_q * ovy_q;
    area_a_q <= sax_q * say_q;
    area_b_q <= sbx_q * sby_q;
    // stage 2: union
    uni_q    <= uni;
    inter_q2 <= inter_q;
    // stage 3: threshold product
    rhs_q    <= Lh'(uni_q) * Lh'(thr);
    inter_q3 <= inter_q2;
    zero_q   <= (uni_q == '0);
  end

  assign uni = Un'(area_a_q) + Un'(area_b_q) - Un'(inter_q);

  // valid pipe
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[2:0], ctl.valid};
    end
  end

  assign hit_valid = vld[3];
  assign hit = !zero_q && !({Lh'(inter_q3), 16'h0000} < {16'h0000, rhs_q});
endmodule

/* rtl/core/fast_nms_box_suppressor_top.sv */
// fast nms box suppressor
// per word: accept in idle, read each stored box in scan, drain the pair pipeline, result in done
// throughput: one word at a time, up to MaxBoxes reads of the box memory
// (one stored box per cycle through a 4 stage pair pipeline)
// reset: synchronous, clears count, state and threshold to 29491
`include "fast_nms_box_suppressor_top_defines.svh"
module fast_nms_box_suppressor_top (
  input  logic          clk,
  input  logic          rst,
  fnms_in_if.sink       in_ch,
  fnms_out_if.source    out_ch,
  input  logic          cfg_we,
  input  logic [15:0]   cfg_wdata
);
  localparam int Ib = fnms_pkg::IdxBits;
  localparam int Cb = fnms_pkg::CntBits;

  fnms_pkg::state_t state, state_next;
  logic [fnms_pkg::ThrBits-1:0] thr;
  logic [Cb-1:0] count, rd_cnt;
  logic [Cb-1:0] pend;
  fnms_pkg::box_t nb;
  logic last_q, keep_acc, over_q;
  logic rd_en;
  fnms_pkg::pair_ctl_t ctl;
  logic rd_vld;
  fnms_pkg::box_t rdata;
  logic hit_valid, hit;
  logic out_valid, out_keep, out_over, out_last;
  logic we;

  // threshold register
  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= fnms_pkg::ThrReset;
    end else if (cfg_we) begin
      thr <= cfg_wdata;
    end
  end

  assign in_ch.ready = (state == fnms_pkg::ST_IDLE);
  assign we = in_ch.valid && in_ch.ready && (count < Cb'(fnms_pkg::MaxBoxes));
  assign rd_en = (state == fnms_pkg::ST_SCAN) && (rd_cnt < count);

  fnms_ram #(.Width(fnms_pkg::BoxBits), .Depth(fnms_pkg::MaxBoxes)) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (count[Ib-1:0]),
    .wdata ({in_ch.center_x, in_ch.center_y, in_ch.span_x, in_ch.span_y}),
    .raddr (rd_cnt[Ib-1:0]),
    .rdata (rdata)
  );

  assign ctl.valid = rd_vld;

  fnms_pair u_pair (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .a         (rdata),
    .b         (nb),
    .thr       (thr),
    .hit_valid (hit_valid),
    .hit       (hit)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      fnms_pkg::ST_IDLE: begin
        if (in_ch.valid) begin
          state_next = fnms_pkg::ST_SCAN;
        end
      end
      fnms_pkg::ST_SCAN: begin
        if (!rd_en) begin
          state_next = fnms_pkg::ST_DRAIN;
        end
      end
      fnms_pkg::ST_DRAIN: begin
        if (pend == '0 && !rd_vld) begin
          state_next = fnms_pkg::ST_DONE;
        end
      end
      fnms_pkg::ST_DONE: begin
        if (!out_valid || out_ch.ready) begin
          state_next = fnms_pkg::ST_IDLE;
        end
      end
      default: state_next = fnms_pkg::ST_IDLE;
    endcase
  end

  // sequencer registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= fnms_pkg::ST_IDLE;
      count     <= '0;
      rd_cnt    <= '0;
      pend      <= '0;
      rd_vld    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state  <= state_next;
      rd_vld <= rd_en;
      if (in_ch.valid && in_ch.ready) begin
        rd_cnt <= '0;
      end else if (rd_en) begin
        rd_cnt <= rd_cnt + 1'b1;
      end
      case ({rd_en, hit_valid})
        2'b10:   pend <= pend + 1'b1;
        2'b01:   pend <= pend - 1'b1;
        default: pend <= pend;
      endcase
      if (state == fnms_pkg::ST_DONE && (!out_valid || out_ch.ready)) begin
        out_valid <= 1'b1;
        if (last_q) begin
          count <= '0;
        end else if (!over_q) begin
          count <= count + 1'b1;
        end
      end else if (out_valid && out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // item payload, keep accumulation and result registers
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      nb       <= {in_ch.center_x, in_ch.center_y, in_ch.span_x, in_ch.span_y};
      last_q   <= in_ch.last_box;
      over_q   <= (count >= Cb'(fnms_pkg::MaxBoxes));
      keep_acc <= (thr != '0);
    end else if (hit_valid && hit) begin
      keep_acc <= 1'b0;
    end
    if (state == fnms_pkg::ST_DONE && (!out_valid || out_ch.ready)) begin
      out_keep <= keep_acc;
      out_over <= over_q;
      out_last <= last_q;
    end
  end

  assign out_ch.valid       = out_valid;
  assign out_ch.keep        = out_keep;
  assign out_ch.overflow    = out_over;
  assign out_ch.last_result = out_last;

  `NMS_ASSERT_IMP(a_no_read_past_count, rd_en, rd_cnt < count, "read beyond stored count")
  `NMS_ASSERT_IMP(a_count_bound, 1'b1, count <= Cb'(fnms_pkg::MaxBoxes), "count overrun")
  `NMS_ASSERT_NEXT(a_hold_out, out_valid && !out_ch.ready, out_valid, "result dropped")
endmodule
